>>> src/mbr_pkg.sv
// Package for the Modbus RTU register master: sizes, codes and the
// command and status bundles between controller and datapath. No dependencies.
`default_nettype none
package mbr_pkg;
    localparam int MaxRegs  = 16;
    localparam int CntW     = $clog2(MaxRegs + 1);
    localparam int WrAW     = (MaxRegs > 1) ? $clog2(MaxRegs) : 1;
    localparam int RxDepth  = 2 * MaxRegs + 5;
    localparam int RxAW     = $clog2(RxDepth);
    localparam int RxIdxW   = $clog2(RxDepth + 1);
    localparam int TxIdxW   = $clog2(2 * MaxRegs + 8);
    localparam int TmoW     = 16;
    localparam int CfgIdxW  = 1;

    localparam logic [15:0] CrcInit  = 16'hFFFF;
    localparam logic [15:0] CrcPoly  = 16'hA001;
    localparam logic [15:0] FbtReset = 16'd1000;
    localparam logic [15:0] IbtReset = 16'd100;

    localparam logic [CfgIdxW-1:0] CFG_FIRST = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_INTER = 1'd1;

    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_START = 2'd1;
    localparam logic [1:0] K_BYTE  = 2'd2;
    localparam logic [1:0] K_TICK  = 2'd3;

    localparam logic [1:0] OK_TX   = 2'd0;
    localparam logic [1:0] OK_WORD = 2'd1;
    localparam logic [1:0] OK_STAT = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNSUP = 3'd1;
    localparam logic [2:0] ST_CRC   = 3'd2;
    localparam logic [2:0] ST_CNT   = 3'd3;
    localparam logic [2:0] ST_TMO   = 3'd4;

    localparam logic [7:0] FN_RD_HOLD  = 8'd3;
    localparam logic [7:0] FN_RD_INPUT = 8'd4;
    localparam logic [7:0] FN_WR_MULTI = 8'd16;

    typedef enum logic [3:0] {
        S_IDLE, S_TX_FETCH, S_TX_SEND, S_TX_CRC, S_TX_CLO, S_TX_CHI,
        S_RX_CRC, S_RX_CHK, S_RD_HI, S_RD_LO, S_RD_OUT, S_STAT
    } t_state;

    typedef struct packed {
        logic       wr_load;
        logic       start_any;
        logic       start;
        logic       rx_take;
        logic       tmo_dec;
        logic       crc_run;
        logic       tx_emit;
        logic       tx_crc_lo;
        logic       tx_crc_hi;
        logic       rd_init;
        logic       rd_lo;
        logic       rd_cap;
        logic       rd_emit;
        logic       stat_set;
        logic [2:0] stat_code;
        logic       stat_emit;
    } t_cmd;

    typedef struct packed {
        logic       fn_ok;
        logic       first_bad;
        logic       overrun;
        logic       crc_upd;
        logic       rx_done;
        logic       tmo_exp;
        logic       crc_last;
        logic       tx_end;
        logic       rd_words;
        logic       cnt_zero;
        logic       rd_last;
        logic [2:0] chk_code;
        logic       out_free;
    } t_sts;
endpackage
`default_nettype wire

>>> src/mbr_if.sv
// Handshake channel interfaces: request items, result items, register writes.
// Depends on mbr_pkg for widths.
`default_nettype none
interface mbr_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  slave_id;
    logic [7:0]  fn_code;
    logic [15:0] base_addr;
    logic [15:0] reg_total;
    logic [15:0] write_word;
    logic [7:0]  rx_byte;
    modport source (output valid, kind, slave_id, fn_code, base_addr,
                    reg_total, write_word, rx_byte, input ready);
    modport sink (input valid, kind, slave_id, fn_code, base_addr,
                  reg_total, write_word, rx_byte, output ready);
endinterface

interface mbr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_word;
    logic [2:0]  status;
    logic [4:0]  done_count;
    logic        last;
    modport source (output valid, out_kind, tx_byte, reg_word, status, done_count,
                    last, input ready);
    modport sink (input valid, out_kind, tx_byte, reg_word, status, done_count,
                  last, output ready);
endinterface

interface mbr_cfg_if;
    import mbr_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] addr;
    logic [15:0]        data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

>>> src/mbr_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none
module mbr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/mbr_ctrl.sv
// Controller state machine: sequences transmit, receive, check and readout.
// Depends on mbr_pkg; drives the datapath through t_cmd.
`default_nettype none
module mbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_kind,
    output logic               o_ready,
    input  wire mbr_pkg::t_sts i_sts,
    output mbr_pkg::t_cmd      o_cmd
);
    import mbr_pkg::*;

    t_state r_state, n_state;
    logic   r_phase, n_phase;
    logic   w_take;

    assign o_ready = (r_state == S_IDLE);
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && i_kind == K_START) begin
                    n_state = i_sts.fn_ok ? S_TX_FETCH : S_STAT;
                end else if (w_take && i_kind == K_BYTE && r_phase
                             && !i_sts.first_bad && !i_sts.overrun) begin
                    n_state = i_sts.crc_upd ? S_RX_CRC : S_RX_CHK;
                end else if (w_take && i_kind == K_TICK && r_phase && i_sts.tmo_exp) begin
                    n_state = S_STAT;
                end
            end
            S_TX_FETCH: n_state = S_TX_SEND;
            S_TX_SEND:  if (i_sts.out_free) n_state = S_TX_CRC;
            S_TX_CRC: begin
                if (i_sts.crc_last) n_state = i_sts.tx_end ? S_TX_CLO : S_TX_FETCH;
            end
            S_TX_CLO:   if (i_sts.out_free) n_state = S_TX_CHI;
            S_TX_CHI:   if (i_sts.out_free) n_state = S_IDLE;
            S_RX_CRC:   if (i_sts.crc_last) n_state = S_RX_CHK;
            S_RX_CHK: begin
                if (!i_sts.rx_done) begin
                    n_state = S_IDLE;
                end else if (i_sts.chk_code == ST_OK && i_sts.rd_words
                             && !i_sts.cnt_zero) begin
                    n_state = S_RD_HI;
                end else begin
                    n_state = S_STAT;
                end
            end
            S_RD_HI:    n_state = S_RD_LO;
            S_RD_LO:    n_state = S_RD_OUT;
            S_RD_OUT: begin
                if (i_sts.out_free) n_state = i_sts.rd_last ? S_STAT : S_RD_HI;
            end
            S_STAT:     if (i_sts.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        n_phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    unique case (i_kind)
                        K_LOAD: o_cmd.wr_load = 1'b1;
                        K_START: begin
                            o_cmd.start_any = 1'b1;
                            if (i_sts.fn_ok) begin
                                o_cmd.start = 1'b1;
                                n_phase     = 1'b1;
                            end else begin
                                o_cmd.stat_set  = 1'b1;
                                o_cmd.stat_code = ST_UNSUP;
                                n_phase         = 1'b0;
                            end
                        end
                        K_BYTE: begin
                            if (r_phase && !i_sts.first_bad) begin
                                if (i_sts.overrun) n_phase = 1'b0;
                                else o_cmd.rx_take = 1'b1;
                            end
                        end
                        K_TICK: begin
                            if (r_phase) begin
                                if (i_sts.tmo_exp) begin
                                    n_phase         = 1'b0;
                                    o_cmd.stat_set  = 1'b1;
                                    o_cmd.stat_code = ST_TMO;
                                end else begin
                                    o_cmd.tmo_dec = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TX_SEND:  o_cmd.tx_emit   = i_sts.out_free;
            S_TX_CRC:   o_cmd.crc_run   = 1'b1;
            S_TX_CLO:   o_cmd.tx_crc_lo = i_sts.out_free;
            S_TX_CHI:   o_cmd.tx_crc_hi = i_sts.out_free;
            S_RX_CRC:   o_cmd.crc_run   = 1'b1;
            S_RX_CHK: begin
                if (i_sts.rx_done) begin
                    n_phase       = 1'b0;
                    o_cmd.rd_init = 1'b1;
                    if (!(i_sts.chk_code == ST_OK && i_sts.rd_words && !i_sts.cnt_zero)) begin
                        o_cmd.stat_set  = 1'b1;
                        o_cmd.stat_code = i_sts.chk_code;
                    end
                end
            end
            S_RD_LO: begin
                o_cmd.rd_lo  = 1'b1;
                o_cmd.rd_cap = 1'b1;
            end
            S_RD_OUT: begin
                o_cmd.rd_lo   = 1'b1;
                o_cmd.rd_emit = i_sts.out_free;
                if (i_sts.out_free && i_sts.rd_last) begin
                    o_cmd.stat_set  = 1'b1;
                    o_cmd.stat_code = ST_OK;
                end
            end
            S_STAT:     o_cmd.stat_emit = i_sts.out_free;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> src/mbr_dp.sv
// Datapath: request and response registers, bit-serial CRC, timeout counter,
// write and receive stores, result register. Depends on mbr_pkg and mbr_ram.
`default_nettype none
module mbr_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [mbr_pkg::CfgIdxW-1:0] i_cfg_addr,
    input  wire logic [15:0]                 i_cfg_data,
    input  wire logic [7:0]                  i_slave_id,
    input  wire logic [7:0]                  i_fn_code,
    input  wire logic [15:0]                 i_base_addr,
    input  wire logic [15:0]                 i_reg_total,
    input  wire logic [15:0]                 i_write_word,
    input  wire logic [7:0]                  i_rx_byte,
    input  wire mbr_pkg::t_cmd               i_cmd,
    output mbr_pkg::t_sts                    o_sts,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic [1:0]                       o_out_kind,
    output logic [7:0]                       o_tx_byte,
    output logic [15:0]                      o_reg_word,
    output logic [2:0]                       o_status,
    output logic [4:0]                       o_done_count,
    output logic                             o_last
);
    import mbr_pkg::*;

    logic [15:0]       r_fbt, r_ibt, r_tmo, r_crc, r_start;
    logic [7:0]        r_slave, r_fn, r_sh, r_bc, r_e4, r_e5, r_prev, r_cur, r_hi;
    logic [CntW-1:0]   r_cnt, r_fill, r_rd_i, r_done;
    logic [RxIdxW-1:0] r_rx_idx;
    logic [TxIdxW-1:0] r_tx_idx;
    logic [2:0]        r_bit, r_stat;
    logic              r_ov;
    logic [1:0]        r_okind;
    logic [7:0]        r_otx;
    logic [15:0]       r_oword;
    logic [2:0]        r_ostat;
    logic [CntW-1:0]   r_odone;
    logic              r_olast;

    logic [RxIdxW-1:0] w_need;
    logic [TxIdxW-1:0] w_txlen, w_off;
    logic [7:0]        w_txb;
    logic [15:0]       w_wr_rdata, w_crc_nx;
    logic [7:0]        w_rx_rdata;
    logic [RxAW-1:0]   w_rx_raddr;
    logic [CntW-1:0]   w_clamp;
    logic              w_wr_we, w_free, w_emit;

    mbr_ram #(.Width(16), .Depth(MaxRegs)) u_wr_ram (
        .i_clk  (i_clk),
        .i_we   (w_wr_we),
        .i_waddr(r_fill[WrAW-1:0]),
        .i_wdata(i_write_word),
        .i_raddr(w_off[WrAW:1]),
        .o_rdata(w_wr_rdata)
    );

    mbr_ram #(.Width(8), .Depth(RxDepth)) u_rx_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.rx_take),
        .i_waddr(r_rx_idx[RxAW-1:0]),
        .i_wdata(i_rx_byte),
        .i_raddr(w_rx_raddr),
        .o_rdata(w_rx_rdata)
    );

    assign w_wr_we = i_cmd.wr_load && (r_fill < CntW'(MaxRegs));
    assign w_clamp = (i_reg_total > 16'(MaxRegs)) ? CntW'(MaxRegs)
                                                  : i_reg_total[CntW-1:0];
    assign w_need  = (r_fn == FN_WR_MULTI) ? RxIdxW'(8)
                                           : RxIdxW'({r_cnt, 1'b0}) + RxIdxW'(5);
    assign w_txlen = (r_fn == FN_WR_MULTI) ? TxIdxW'({r_cnt, 1'b0}) + TxIdxW'(7)
                                           : TxIdxW'(6);
    assign w_off   = r_tx_idx - TxIdxW'(7);
    assign w_rx_raddr = RxAW'({r_rd_i, 1'b0}) + (i_cmd.rd_lo ? RxAW'(4) : RxAW'(3));
    assign w_crc_nx = r_crc[0] ^ r_sh[0] ? ((r_crc >> 1) ^ CrcPoly) : (r_crc >> 1);

    always_comb begin
        unique case (r_tx_idx)
            TxIdxW'(0): w_txb = r_slave;
            TxIdxW'(1): w_txb = r_fn;
            TxIdxW'(2): w_txb = r_start[15:8];
            TxIdxW'(3): w_txb = r_start[7:0];
            TxIdxW'(4): w_txb = 8'h00;
            TxIdxW'(5): w_txb = 8'(r_cnt);
            TxIdxW'(6): w_txb = 8'({r_cnt, 1'b0});
            default:    w_txb = w_off[0] ? w_wr_rdata[7:0] : w_wr_rdata[15:8];
        endcase
    end

    assign w_free = !r_ov || i_out_ready;
    assign w_emit = i_cmd.tx_emit || i_cmd.tx_crc_lo || i_cmd.tx_crc_hi
                 || i_cmd.rd_emit || i_cmd.stat_emit;

    always_comb begin
        o_sts           = '0;
        o_sts.fn_ok     = (i_fn_code == FN_RD_HOLD) || (i_fn_code == FN_RD_INPUT)
                       || (i_fn_code == FN_WR_MULTI);
        o_sts.first_bad = (r_rx_idx == '0) && (i_rx_byte != r_slave);
        o_sts.overrun   = (r_rx_idx >= w_need);
        o_sts.crc_upd   = ({1'b0, r_rx_idx} + (RxIdxW+1)'(2)) < {1'b0, w_need};
        o_sts.rx_done   = (r_rx_idx == w_need);
        o_sts.tmo_exp   = (r_tmo <= 16'd1);
        o_sts.crc_last  = (r_bit == 3'd7);
        o_sts.tx_end    = (r_tx_idx == w_txlen);
        o_sts.rd_words  = (r_fn != FN_WR_MULTI);
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.rd_last   = ((CntW+1)'(r_rd_i) + (CntW+1)'(1)) == (CntW+1)'(r_cnt);
        o_sts.out_free  = w_free;
        if (r_prev != r_crc[7:0] || r_cur != r_crc[15:8]) begin
            o_sts.chk_code = ST_CRC;
        end else if (r_fn == FN_WR_MULTI) begin
            o_sts.chk_code = ({r_e4, r_e5} != 16'(r_cnt)) ? ST_CNT : ST_OK;
        end else begin
            o_sts.chk_code = (r_bc != 8'({r_cnt, 1'b0})) ? ST_CNT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fbt    <= FbtReset;
            r_ibt    <= IbtReset;
            r_tmo    <= '0;
            r_crc    <= CrcInit;
            r_slave  <= '0;
            r_fn     <= '0;
            r_cnt    <= '0;
            r_fill   <= '0;
            r_rx_idx <= '0;
            r_tx_idx <= '0;
            r_rd_i   <= '0;
            r_bit    <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_FIRST) r_fbt <= i_cfg_data;
            if (i_cfg_we && i_cfg_addr == CFG_INTER) r_ibt <= i_cfg_data;
            if (w_wr_we) r_fill <= r_fill + CntW'(1);
            if (i_cmd.start_any) r_fill <= '0;
            if (i_cmd.start) begin
                r_slave  <= i_slave_id;
                r_fn     <= i_fn_code;
                r_cnt    <= w_clamp;
                r_tmo    <= r_fbt;
                r_crc    <= CrcInit;
                r_tx_idx <= '0;
                r_rx_idx <= '0;
            end
            if (i_cmd.tx_crc_hi) r_crc <= CrcInit;
            if (i_cmd.tmo_dec) r_tmo <= r_tmo - 16'd1;
            if (i_cmd.rx_take) begin
                r_rx_idx <= r_rx_idx + RxIdxW'(1);
                r_tmo    <= r_ibt;
                r_bit    <= '0;
            end
            if (i_cmd.tx_emit) begin
                r_tx_idx <= r_tx_idx + TxIdxW'(1);
                r_bit    <= '0;
            end
            if (i_cmd.crc_run) begin
                r_crc <= w_crc_nx;
                r_bit <= r_bit + 3'd1;
            end
            if (i_cmd.rd_init) r_rd_i <= '0;
            if (i_cmd.rd_emit) r_rd_i <= r_rd_i + CntW'(1);
            if (w_emit) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_start <= i_base_addr;
        if (i_cmd.rx_take) begin
            r_sh   <= i_rx_byte;
            r_prev <= r_cur;
            r_cur  <= i_rx_byte;
            if (r_rx_idx == RxIdxW'(2)) r_bc <= i_rx_byte;
            if (r_rx_idx == RxIdxW'(4)) r_e4 <= i_rx_byte;
            if (r_rx_idx == RxIdxW'(5)) r_e5 <= i_rx_byte;
        end
        if (i_cmd.tx_emit) r_sh <= w_txb;
        if (i_cmd.crc_run) r_sh <= r_sh >> 1;
        if (i_cmd.rd_cap) r_hi <= w_rx_rdata;
        if (i_cmd.stat_set) begin
            r_stat <= i_cmd.stat_code;
            r_done <= (i_cmd.stat_code == ST_OK) ? r_cnt : '0;
        end
        if (w_emit) begin
            r_okind <= OK_TX;
            r_otx   <= '0;
            r_oword <= '0;
            r_ostat <= ST_OK;
            r_odone <= '0;
            r_olast <= 1'b0;
            priority if (i_cmd.tx_emit) begin
                r_otx <= w_txb;
            end else if (i_cmd.tx_crc_lo) begin
                r_otx <= r_crc[7:0];
            end else if (i_cmd.tx_crc_hi) begin
                r_otx   <= r_crc[15:8];
                r_olast <= 1'b1;
            end else if (i_cmd.rd_emit) begin
                r_okind <= OK_WORD;
                r_oword <= {r_hi, w_rx_rdata};
            end else begin
                r_okind <= OK_STAT;
                r_ostat <= r_stat;
                r_odone <= r_done;
                r_olast <= 1'b1;
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_kind   = r_okind;
    assign o_tx_byte    = r_otx;
    assign o_reg_word   = r_oword;
    assign o_status     = r_ostat;
    assign o_done_count = 5'(r_odone);
    assign o_last       = r_olast;
endmodule
`default_nettype wire

>>> src/modbus_rtu_register_master.sv
// Modbus RTU register master, functions 3, 4 and 16, with CRC-16/MODBUS.
// Top level: joins mbr_ctrl and mbr_dp; depends on mbr_pkg and mbr_if.
//
// Usage:
//  i_item carries one item per transfer: load a write word, start a request,
//  a received serial byte, or a timer tick. o_res carries transmit bytes,
//  read register words and one final status per transaction; last marks the
//  end of each item's results. i_cfg writes the two timeout registers and is
//  always ready.
//  Timing: a load or a tick is taken in idle and, when it ends in a status,
//  passes through the status state. A start emits each frame byte and then
//  shifts it through the bit-serial CRC unit, then emits the CRC bytes. A
//  received byte is stored, shifted through the CRC unit when it is covered
//  by the CRC, and checked. A good read response then emits each word in turn.
//  The CRC shift loop sets the throughput; i_item is not ready while a
//  request or response is being processed.
//  A full result register holds its value while o_res.ready is low; the
//  block stalls only when it needs the next result slot.
//  Reset (synchronous, active low) returns to idle, clears the write fill
//  and loads the timeouts with 1000 and 100 ticks. No clearing pass.
`default_nettype none
module modbus_rtu_register_master (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mbr_item_if.sink  i_item,
    mbr_res_if.source o_res,
    mbr_cfg_if.sink   i_cfg
);
    import mbr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign i_item.ready = w_ready;
    assign i_cfg.ready  = 1'b1;

    mbr_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_item.valid),
        .i_kind (i_item.kind),
        .o_ready(w_ready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    mbr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_addr      (i_cfg.addr),
        .i_cfg_data      (i_cfg.data),
        .i_slave_id      (i_item.slave_id),
        .i_fn_code       (i_item.fn_code),
        .i_base_addr     (i_item.base_addr),
        .i_reg_total     (i_item.reg_total),
        .i_write_word    (i_item.write_word),
        .i_rx_byte       (i_item.rx_byte),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_out_kind      (o_res.out_kind),
        .o_tx_byte       (o_res.tx_byte),
        .o_reg_word      (o_res.reg_word),
        .o_status        (o_res.status),
        .o_done_count    (o_res.done_count),
        .o_last          (o_res.last)
    );
endmodule
`default_nettype wire

>>> verif/tb.sv
// Testbench for modbus_rtu_register_master: directed table, then random transactions,
// all results checked in order against an in-bench model of the master.
// Depends on mbr_pkg, the mbr_if interfaces and the RTL under src.
`timescale 1ns / 100ps
module tb;
    import mbr_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  sid;
        logic [7:0]  fn;
        logic [15:0] start;
        logic [15:0] cnt;
        logic [15:0] word;
        logic [7:0]  rxb;
    } t_item;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [15:0] word;
        logic [2:0]  st;
        logic [4:0]  done;
        logic        last;
    } t_res;

    typedef enum int {R_NONE, R_GOOD, R_BADCRC, R_BADCNT, R_TMO, R_PART} t_resp;

    typedef struct {
        t_item      it;
        t_resp      resp;
        bit         chk;
        logic [2:0] est;
        bit         cfg;
        logic [15:0] c0;
        logic [15:0] c1;
    } t_row;

    logic clk;
    logic rst_n;
    mbr_item_if item_if();
    mbr_res_if  res_if();
    mbr_cfg_if  cfg_if();

    modbus_rtu_register_master u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_item (item_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    t_res        exp_res_q[$];
    t_row        dir_tab[$];
    int          errors;
    int          n_items;
    bit          no_idle;
    bit          hold_req;

    logic [15:0] fbt_reg, ibt_reg;
    bit          rx_busy;
    logic [7:0]  req_slave, req_fn;
    int          req_cnt;
    logic [15:0] wr_mem[MaxRegs];
    int          wr_fill;
    logic [7:0]  rx_mem[RxDepth];
    int          rx_idx;
    logic [15:0] rx_crc;
    int          tmo_left;

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        return c;
    endfunction

    function automatic void push_res(logic [1:0] k, logic [7:0] tx, logic [15:0] w,
                                     logic [2:0] st, logic [4:0] d, logic l);
        t_res r;
        r.kind = k; r.tx = tx; r.word = w; r.st = st; r.done = d; r.last = l;
        exp_res_q.push_back(r);
    endfunction

    function automatic void predict(t_item it);
        logic [7:0]  fr[7 + 2 * MaxRegs];
        logic [15:0] c, w;
        int          len, fill, need;
        fill = wr_fill;
        case (it.kind)
            K_LOAD: begin
                if (wr_fill < MaxRegs) begin
                    wr_mem[wr_fill] = it.word;
                    wr_fill++;
                end
            end
            K_START: begin
                wr_fill = 0;
                rx_busy = 0;
                if (it.fn != FN_RD_HOLD && it.fn != FN_RD_INPUT && it.fn != FN_WR_MULTI) begin
                    push_res(OK_STAT, 0, 0, ST_UNSUP, 0, 1);
                    return;
                end
                req_cnt = (it.cnt > MaxRegs) ? MaxRegs : it.cnt;
                req_slave = it.sid;
                req_fn = it.fn;
                fr[0] = it.sid; fr[1] = it.fn;
                fr[2] = it.start[15:8]; fr[3] = it.start[7:0];
                fr[4] = 8'(req_cnt >> 8); fr[5] = 8'(req_cnt);
                len = 6;
                if (it.fn == FN_WR_MULTI) begin
                    fr[6] = 8'(2 * req_cnt);
                    len = 7;
                    for (int i = 0; i < req_cnt; i++) begin
                        w = (i < fill) ? wr_mem[i] : 16'h0;
                        fr[len++] = w[15:8];
                        fr[len++] = w[7:0];
                    end
                end
                c = CrcInit;
                for (int i = 0; i < len; i++) begin
                    c = crc_step(c, fr[i]);
                    push_res(OK_TX, fr[i], 0, 0, 0, 0);
                end
                push_res(OK_TX, c[7:0], 0, 0, 0, 0);
                push_res(OK_TX, c[15:8], 0, 0, 0, 1);
                rx_idx = 0;
                rx_crc = CrcInit;
                tmo_left = fbt_reg;
                rx_busy = 1;
            end
            K_TICK: begin
                if (!rx_busy) return;
                if (tmo_left <= 1) begin
                    tmo_left = 0;
                    rx_busy = 0;
                    push_res(OK_STAT, 0, 0, ST_TMO, 0, 1);
                end else begin
                    tmo_left--;
                end
            end
            default: begin
                if (!rx_busy) return;
                need = (req_fn == FN_WR_MULTI) ? 8 : 2 * req_cnt + 5;
                if (rx_idx == 0 && it.rxb != req_slave) return;
                if (rx_idx >= need) begin
                    rx_busy = 0;
                    return;
                end
                rx_mem[rx_idx] = it.rxb;
                if (rx_idx + 2 < need) rx_crc = crc_step(rx_crc, it.rxb);
                rx_idx++;
                tmo_left = ibt_reg;
                if (rx_idx < need) return;
                rx_busy = 0;
                if (rx_mem[need-2] != rx_crc[7:0] || rx_mem[need-1] != rx_crc[15:8]) begin
                    push_res(OK_STAT, 0, 0, ST_CRC, 0, 1);
                end else if (req_fn == FN_WR_MULTI) begin
                    if ({rx_mem[4], rx_mem[5]} != req_cnt)
                        push_res(OK_STAT, 0, 0, ST_CNT, 0, 1);
                    else
                        push_res(OK_STAT, 0, 0, ST_OK, 5'(req_cnt), 1);
                end else if (rx_mem[2] != 2 * req_cnt) begin
                    push_res(OK_STAT, 0, 0, ST_CNT, 0, 1);
                end else begin
                    for (int i = 0; i < req_cnt; i++)
                        push_res(OK_WORD, 0, {rx_mem[2*i+3], rx_mem[2*i+4]}, 0, 0, 0);
                    push_res(OK_STAT, 0, 0, ST_OK, 5'(req_cnt), 1);
                end
            end
        endcase
    endfunction

    function automatic t_item mk(logic [1:0] k, logic [7:0] sid, logic [7:0] fn,
                                 logic [15:0] st, logic [15:0] cnt, logic [15:0] w,
                                 logic [7:0] b);
        t_item it;
        it.kind = k; it.sid = sid; it.fn = fn; it.start = st; it.cnt = cnt;
        it.word = w; it.rxb = b;
        return it;
    endfunction

    function automatic t_item rnd_item(logic [1:0] k);
        return mk(k, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 8'($urandom));
    endfunction

    function automatic void add_row(t_item it, t_resp resp, bit chk, logic [2:0] est);
        t_row r;
        r.it = it; r.resp = resp; r.chk = chk; r.est = est; r.cfg = 0; r.c0 = 0; r.c1 = 0;
        dir_tab.push_back(r);
    endfunction

    function automatic void add_cfg(logic [15:0] a, logic [15:0] b);
        t_row r;
        r.it = mk(K_TICK, 0, 0, 0, 0, 0, 0);
        r.resp = R_NONE; r.chk = 0; r.est = 0; r.cfg = 1; r.c0 = a; r.c1 = b;
        dir_tab.push_back(r);
    endfunction

    task automatic send(t_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid      <= 1'b1;
        item_if.kind       <= it.kind;
        item_if.slave_id   <= it.sid;
        item_if.fn_code    <= it.fn;
        item_if.base_addr  <= it.start;
        item_if.reg_total  <= it.cnt;
        item_if.write_word <= it.word;
        item_if.rx_byte    <= it.rxb;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        predict(it);
        n_items++;
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (exp_res_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_cfg(logic [15:0] fbt, logic [15:0] ibt);
        drain();
        for (int i = 0; i < 2; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.addr  <= (i == 0) ? CFG_FIRST : CFG_INTER;
            cfg_if.data  <= (i == 0) ? fbt : ibt;
            @(posedge clk);
            while (!cfg_if.ready) @(posedge clk);
            if (i == 0) fbt_reg = fbt; else ibt_reg = ibt;
        end
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic respond(t_resp mode);
        logic [7:0]  bq[$];
        logic [15:0] c;
        int          need, cut;
        if (mode == R_NONE) return;
        bq.push_back(req_slave);
        bq.push_back(req_fn);
        if (req_fn == FN_WR_MULTI) begin
            bq.push_back(8'($urandom));
            bq.push_back(8'($urandom));
            c = (mode == R_BADCNT) ? 16'(req_cnt + $urandom_range(1, 300)) : 16'(req_cnt);
            bq.push_back(c[15:8]);
            bq.push_back(c[7:0]);
        end else begin
            bq.push_back((mode == R_BADCNT) ? 8'(2 * req_cnt + 1) : 8'(2 * req_cnt));
            for (int i = 0; i < 2 * req_cnt; i++) bq.push_back(8'($urandom));
        end
        c = CrcInit;
        foreach (bq[i]) c = crc_step(c, bq[i]);
        if (mode == R_BADCRC) c = c ^ (16'h1 << $urandom_range(0, 15));
        bq.push_back(c[7:0]);
        bq.push_back(c[15:8]);
        need = bq.size();
        cut = (mode == R_TMO || mode == R_PART) ? $urandom_range(0, need - 1) : need;
        for (int i = 0; i < cut; i++) send(mk(K_BYTE, 0, 0, 0, 0, 0, bq[i]));
        if (mode == R_TMO)
            while (rx_busy) send(mk(K_TICK, 8'($urandom), 0, 0, 0, 0, 0));
    endtask

    task automatic transaction();
        t_item st;
        int    r, c, nload;
        t_resp mode;
        st = rnd_item(K_START);
        r = $urandom_range(0, 99);
        st.fn = (r < 35) ? FN_RD_HOLD : (r < 60) ? FN_RD_INPUT : (r < 90) ? FN_WR_MULTI
                : 8'($urandom);
        st.cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, MaxRegs));
        c = (st.cnt > MaxRegs) ? MaxRegs : st.cnt;
        if (st.fn == FN_WR_MULTI) begin
            nload = c + $urandom_range(0, 2);
            for (int i = 0; i < nload; i++) send(rnd_item(K_LOAD));
        end
        send(st);
        if (!rx_busy) return;
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send(rnd_item(K_BYTE));
        r = $urandom_range(0, 99);
        mode = (r < 55) ? R_GOOD : (r < 70) ? R_BADCRC : (r < 82) ? R_BADCNT
               : (r < 94) ? R_TMO : R_PART;
        if (mode == R_TMO && (fbt_reg > 40 || ibt_reg > 40)) mode = R_GOOD;
        respond(mode);
        if ($urandom_range(0, 5) == 0) send(rnd_item(K_BYTE));
    endtask

    task automatic noise();
        t_item it;
        int    r;
        r = $urandom_range(0, 3);
        it = rnd_item((r == 0) ? K_LOAD : (r == 1) ? K_BYTE : (r == 2) ? K_TICK : K_START);
        if (it.kind == K_START)
            while (it.fn == FN_RD_HOLD || it.fn == FN_RD_INPUT || it.fn == FN_WR_MULTI)
                it.fn = 8'($urandom);
        send(it);
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int st;
        t_res e;
        res_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            st = hold_req ? 300 : (no_idle ? 0 : $urandom_range(0, 18));
            hold_req = 0;
            if (st > 0) begin
                res_if.ready <= 1'b0;
                repeat (st) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid) @(posedge clk);
            if (exp_res_q.size() == 0) begin
                $display("%0t: unexpected result kind %0d", $time, res_if.out_kind);
                errors++;
            end else begin
                e = exp_res_q.pop_front();
                if (res_if.out_kind !== e.kind) begin
                    $display("%0t: out_kind exp %0d got %0d", $time, e.kind, res_if.out_kind);
                    errors++;
                end
                if (res_if.tx_byte !== e.tx) begin
                    $display("%0t: tx_byte exp %h got %h", $time, e.tx, res_if.tx_byte);
                    errors++;
                end
                if (res_if.reg_word !== e.word) begin
                    $display("%0t: reg_word exp %h got %h", $time, e.word, res_if.reg_word);
                    errors++;
                end
                if (res_if.status !== e.st) begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, res_if.status);
                    errors++;
                end
                if (res_if.done_count !== e.done) begin
                    $display("%0t: done_count exp %0d got %0d", $time, e.done,
                             res_if.done_count);
                    errors++;
                end
                if (res_if.last !== e.last) begin
                    $display("%0t: last exp %0d got %0d", $time, e.last, res_if.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int  phase_mark;
        bit  held;
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.kind = K_LOAD;
        item_if.slave_id = 0;
        item_if.fn_code = 0;
        item_if.base_addr = 0;
        item_if.reg_total = 0;
        item_if.write_word = 0;
        item_if.rx_byte = 0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = CFG_FIRST;
        cfg_if.data = 0;
        errors = 0; n_items = 0; no_idle = 0; hold_req = 0; held = 0;
        fbt_reg = FbtReset; ibt_reg = IbtReset;
        rx_busy = 0; req_slave = 0; req_fn = 0; req_cnt = 0; wr_fill = 0;
        rx_idx = 0; rx_crc = CrcInit; tmo_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(mk(K_TICK, 0, 0, 0, 0, 0, 0), R_NONE, 0, 0);
        add_row(mk(K_BYTE, 0, 0, 0, 0, 0, 8'h11), R_NONE, 0, 0);
        add_row(mk(K_START, 8'h01, 8'h00, 0, 1, 0, 0), R_NONE, 1, ST_UNSUP);
        add_row(mk(K_START, 8'h01, 8'hFF, 16'hFFFF, 16'hFFFF, 0, 0), R_NONE, 1, ST_UNSUP);
        add_row(mk(K_START, 8'hFF, FN_RD_HOLD, 16'hFFFF, 16'hFFFF, 0, 0), R_GOOD, 0, 0);
        add_row(mk(K_START, 8'h00, FN_RD_INPUT, 0, 0, 0, 0), R_GOOD, 0, 0);
        add_row(mk(K_LOAD, 0, 0, 0, 0, 16'hFFFF, 0), R_NONE, 0, 0);
        add_row(mk(K_LOAD, 0, 0, 0, 0, 16'h0000, 0), R_NONE, 0, 0);
        add_row(mk(K_LOAD, 0, 0, 0, 0, 16'h8001, 0), R_NONE, 0, 0);
        add_row(mk(K_START, 8'h5A, FN_WR_MULTI, 16'h1234, 3, 0, 0), R_GOOD, 0, 0);
        add_row(mk(K_START, 8'h21, FN_RD_HOLD, 16'h0010, 2, 0, 0), R_BADCRC, 0, 0);
        add_row(mk(K_START, 8'h22, FN_RD_INPUT, 16'h0020, 2, 0, 0), R_BADCNT, 0, 0);
        add_row(mk(K_LOAD, 0, 0, 0, 0, 16'h7FFE, 0), R_NONE, 0, 0);
        add_row(mk(K_START, 8'h33, FN_WR_MULTI, 16'h0001, 1, 0, 0), R_BADCNT, 0, 0);
        add_cfg(16'd1, 16'd1);
        add_row(mk(K_START, 8'h07, FN_RD_HOLD, 0, 1, 0, 0), R_NONE, 0, 0);
        add_row(mk(K_TICK, 0, 0, 0, 0, 0, 0), R_NONE, 1, ST_TMO);
        add_row(mk(K_START, 8'h07, FN_RD_HOLD, 0, 1, 0, 0), R_NONE, 0, 0);
        add_row(mk(K_BYTE, 0, 0, 0, 0, 0, 8'h07), R_NONE, 0, 0);
        add_row(mk(K_TICK, 0, 0, 0, 0, 0, 0), R_NONE, 1, ST_TMO);
        add_row(mk(K_START, 8'h09, FN_RD_INPUT, 0, 1, 0, 0), R_NONE, 0, 0);
        add_row(mk(K_START, 8'h09, FN_RD_HOLD, 16'h8000, 1, 0, 0), R_GOOD, 0, 0);
        add_cfg(16'hFFFF, 16'hFFFF);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg) begin
                write_cfg(dir_tab[i].c0, dir_tab[i].c1);
            end else begin
                send(dir_tab[i].it);
                if (dir_tab[i].chk && exp_res_q.size() != 0) begin
                    void'(exp_res_q.pop_back());
                    push_res(OK_STAT, 0, 0, dir_tab[i].est, 0, 1);
                end
                respond(dir_tab[i].resp);
            end
        end

        phase_mark = n_items;
        while (n_items < 430) begin
            if (n_items - phase_mark >= 90) begin
                phase_mark = n_items;
                case ($urandom_range(0, 3))
                    0: write_cfg(16'd1, 16'd1);
                    1: write_cfg(16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)));
                    2: write_cfg(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
                    default: write_cfg(16'd3, 16'd2);
                endcase
            end
            if (!held && n_items > 150) begin
                held = 1;
                hold_req = 1;
            end
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 7) transaction();
            else noise();
        end
        no_idle = 0;
        drain();
        if (errors == 0 && exp_res_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
